// ===== hdl/sector_cache_slot_manager_macros.svh =====
// Assertion macros shared by the sector cache slot manager RTL.
// Needs nothing else; include it inside a module body.
`ifndef SECTOR_CACHE_SLOT_MANAGER_MACROS_SVH
`define SECTOR_CACHE_SLOT_MANAGER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define SCSM_ASSERT_NOW(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SCSM_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== hdl/scsm_pkg.sv =====
// Types and constants for the sector cache slot manager.
// No dependencies; imported by sector_cache_slot_manager.
package scsm_pkg;

   localparam int SLOTS  = 8;
   localparam int SLOT_W = $clog2(SLOTS);
   localparam int TAG_W  = 32;
   localparam int AGE_W  = 32;

   localparam logic CMD_REQUEST = 1'b0;
   localparam logic CMD_DONE    = 1'b1;

   typedef logic [SLOT_W-1:0] slot_idx_type;

   typedef enum logic [1:0] {
      LINE_EMPTY   = 2'd0,
      LINE_READING = 2'd1,
      LINE_IN_SYNC = 2'd2
   } line_state_type;

   typedef struct packed {
      logic [TAG_W-1:0] tag;
      line_state_type   state;
      logic [AGE_W-1:0] age;
   } slot_entry_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DRAIN,
      ST_CREAD,
      ST_DECIDE
   } fsm_state_type;

endpackage

// ===== hdl/sector_cache_slot_manager.sv =====
// Sector cache slot manager: tag, line state and age per slot in one RAM.
// Depends on scsm_pkg and sector_cache_slot_manager_macros.svh.
//
// Use: a request item (cmd 0) asks for a disk block; the result says which
// slot holds or was given the block, whether it is ready and whether a card
// read starts now. A completion item (cmd 1) marks done_slot in sync when its
// tag matches block_index; such a matching completion for a slot that was not
// reading sets the sticky fatal flag, which every result carries.
// Items are taken one at a time. A request reads the slot RAM one entry a
// cycle in its scan step, then passes a drain step and a decide step; a
// completion reads one entry and then decides. The sequential walk over the
// single RAM read port sets this order.
// Every item gives exactly one result item, held in an output register; the
// next item is taken while that result still waits.
// Stall: a stalled result holds; a finished item waits in its decide step
// until the output register is free, and req_stall stays high meanwhile.
// Reset: synchronous, active high. Per-slot valid flops clear at once, so
// an unwritten slot reads as tag 0, empty, age 0. No clearing pass is needed.
module sector_cache_slot_manager (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic        req_cmd,
   input  logic [31:0] req_block_index,
   input  logic [2:0]  req_done_slot,
   input  logic        req_card_accepts,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_status,
   output logic [2:0]  rsp_slot,
   output logic        rsp_slot_valid,
   output logic        rsp_issue_read,
   output logic        rsp_fatal
);
   import scsm_pkg::*;

   `include "sector_cache_slot_manager_macros.svh"

   // Slot RAM, one entry per slot, registered read
   slot_entry_type mem [SLOTS];
   slot_entry_type rd_data_ff;
   logic           rd_vld_ff;          // entry had been written
   logic [SLOTS-1:0] entry_valid_ff;

   fsm_state_type state_ff, state_in;

   // Item held for the whole operation
   logic             item_cmd_ff;
   logic [TAG_W-1:0] item_blk_ff;
   logic [2:0]       item_done_ff;
   logic             item_accepts_ff;

   slot_idx_type addr_ff, addr_in;     // scan read address
   slot_idx_type eval_idx_ff;          // index of the data in rd_data_ff
   logic         eval_ff;              // rd_data_ff is a scan entry to judge

   // Scan trackers
   logic           hit_ff, hit_in;
   slot_idx_type   hit_idx_ff, hit_idx_in;
   line_state_type hit_state_ff, hit_state_in;
   logic           empty_ff, empty_in;
   slot_idx_type   empty_idx_ff, empty_idx_in;
   logic           lru_ff, lru_in;
   slot_idx_type   lru_idx_ff, lru_idx_in;
   logic [AGE_W-1:0] lru_age_ff, lru_age_in;

   logic [AGE_W-1:0] use_clock_ff, use_clock_in;
   logic             fatal_ff, fatal_in;

   // Output register
   logic       rsp_valid_ff, rsp_valid_in;
   logic       rsp_status_ff, rsp_status_in;
   logic [2:0] rsp_slot_ff, rsp_slot_in;
   logic       rsp_slot_valid_ff, rsp_slot_valid_in;
   logic       rsp_issue_ff, rsp_issue_in;
   logic       rsp_fatal_ff, rsp_fatal_in;

   logic           accept;
   logic           out_free;
   logic           scan_last;
   logic           rd_en;
   slot_idx_type   rd_addr;
   slot_idx_type   cmpl_addr;
   logic           cmpl_in_range;
   slot_entry_type eff;                // read data, unwritten entries as reset value
   logic           wr_en;
   slot_idx_type   wr_addr;
   slot_entry_type wr_data;
   logic           decide_fire;
   logic           found;
   slot_idx_type   pick_idx;
   line_state_type pick_state;

   assign accept        = req_valid && !req_stall;
   assign out_free      = !rsp_valid_ff || !rsp_stall;
   assign scan_last     = (addr_ff == SLOT_W'(SLOTS - 1));
   assign cmpl_in_range = (32'(item_done_ff) < 32'(SLOTS));
   assign cmpl_addr     = SLOT_W'(item_done_ff);
   assign eff           = rd_vld_ff ? rd_data_ff : '0;

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = (req_cmd == CMD_DONE) ? ST_CREAD : ST_SCAN;
            end
         end
         ST_SCAN: begin
            if (scan_last) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN:  state_in = ST_DECIDE;
         ST_CREAD:  state_in = ST_DECIDE;
         ST_DECIDE: begin
            if (out_free) begin
               state_in = ST_IDLE;
            end
         end
         default:   state_in = ST_IDLE;
      endcase
   end

   // Outputs of the sequencer: RAM access, scan trackers, result
   always_comb begin
      req_stall   = (state_ff != ST_IDLE);
      rd_en       = (state_ff == ST_SCAN) || (state_ff == ST_CREAD);
      rd_addr     = (state_ff == ST_SCAN) ? addr_ff : cmpl_addr;
      addr_in     = (state_ff == ST_SCAN) ? addr_ff + 1'b1 : '0;
      decide_fire = (state_ff == ST_DECIDE) && out_free;

      hit_in       = hit_ff;
      hit_idx_in   = hit_idx_ff;
      hit_state_in = hit_state_ff;
      empty_in     = empty_ff;
      empty_idx_in = empty_idx_ff;
      lru_in       = lru_ff;
      lru_idx_in   = lru_idx_ff;
      lru_age_in   = lru_age_ff;
      if (accept) begin
         hit_in   = 1'b0;
         empty_in = 1'b0;
         lru_in   = 1'b0;
      end else if (eval_ff) begin
         // first match wins; last empty slot wins; oldest in-sync, lowest on tie
         if (!hit_ff && eff.tag == item_blk_ff) begin
            hit_in       = 1'b1;
            hit_idx_in   = eval_idx_ff;
            hit_state_in = eff.state;
         end
         if (eff.state == LINE_EMPTY) begin
            empty_in     = 1'b1;
            empty_idx_in = eval_idx_ff;
         end else if (eff.state == LINE_IN_SYNC) begin
            if (!lru_ff || eff.age < lru_age_ff) begin
               lru_in     = 1'b1;
               lru_idx_in = eval_idx_ff;
               lru_age_in = eff.age;
            end
         end
      end

      found      = hit_ff || empty_ff || lru_ff;
      pick_idx   = hit_ff ? hit_idx_ff : (empty_ff ? empty_idx_ff : lru_idx_ff);
      pick_state = hit_ff ? hit_state_ff : LINE_EMPTY;

      wr_en             = 1'b0;
      wr_addr           = pick_idx;
      wr_data           = '0;
      use_clock_in      = use_clock_ff;
      fatal_in          = fatal_ff;
      rsp_status_in     = 1'b0;
      rsp_slot_in       = 3'd0;
      rsp_slot_valid_in = 1'b0;
      rsp_issue_in      = 1'b0;

      if (item_cmd_ff == CMD_DONE) begin
         rsp_slot_in = item_done_ff;
         wr_addr     = cmpl_addr;
         wr_data     = eff;
         wr_data.state = LINE_IN_SYNC;
         if (cmpl_in_range && eff.tag == item_blk_ff) begin
            rsp_slot_valid_in = 1'b1;
            wr_en             = decide_fire;
            if (eff.state != LINE_READING) begin
               fatal_in = decide_fire ? 1'b1 : fatal_ff;
            end
         end
      end else if (found) begin
         // a hit has tag == block already, so the tag is always rewritten
         wr_en             = decide_fire;
         wr_data.tag       = item_blk_ff;
         wr_data.age       = use_clock_ff + 1'b1;
         wr_data.state     = pick_state;
         rsp_slot_in       = 3'(pick_idx);
         rsp_slot_valid_in = 1'b1;
         if (decide_fire) begin
            use_clock_in = use_clock_ff + 1'b1;
         end
         if (pick_state == LINE_EMPTY && item_accepts_ff) begin
            wr_data.state = LINE_READING;
            rsp_issue_in  = 1'b1;
         end
         rsp_status_in = (pick_state == LINE_IN_SYNC);
      end
      rsp_fatal_in = (item_cmd_ff == CMD_DONE && cmpl_in_range
                      && eff.tag == item_blk_ff && eff.state != LINE_READING)
                     ? 1'b1 : fatal_ff;

      rsp_valid_in = decide_fire ? 1'b1 : (rsp_valid_ff && rsp_stall);
   end

   // Slot RAM
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   // Control state
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff       <= ST_IDLE;
         entry_valid_ff <= '0;
         use_clock_ff   <= '0;
         fatal_ff       <= 1'b0;
         rsp_valid_ff   <= 1'b0;
         eval_ff        <= 1'b0;
         addr_ff        <= '0;
         hit_ff         <= 1'b0;
         empty_ff       <= 1'b0;
         lru_ff         <= 1'b0;
      end else begin
         state_ff     <= state_in;
         use_clock_ff <= use_clock_in;
         fatal_ff     <= fatal_in;
         rsp_valid_ff <= rsp_valid_in;
         eval_ff      <= rd_en && (item_cmd_ff == CMD_REQUEST);
         addr_ff      <= addr_in;
         hit_ff       <= hit_in;
         empty_ff     <= empty_in;
         lru_ff       <= lru_in;
         if (wr_en) begin
            entry_valid_ff[wr_addr] <= 1'b1;
         end
      end
   end

   // Payload registers
   always_ff @(posedge clock) begin
      if (accept) begin
         item_cmd_ff     <= req_cmd;
         item_blk_ff     <= req_block_index;
         item_done_ff    <= req_done_slot;
         item_accepts_ff <= req_card_accepts;
      end
      if (rd_en) begin
         rd_vld_ff   <= entry_valid_ff[rd_addr];
         eval_idx_ff <= rd_addr;
      end
      hit_idx_ff   <= hit_idx_in;
      hit_state_ff <= hit_state_in;
      empty_idx_ff <= empty_idx_in;
      lru_idx_ff   <= lru_idx_in;
      lru_age_ff   <= lru_age_in;
      if (decide_fire) begin
         rsp_status_ff     <= rsp_status_in;
         rsp_slot_ff       <= rsp_slot_in;
         rsp_slot_valid_ff <= rsp_slot_valid_in;
         rsp_issue_ff      <= rsp_issue_in;
         rsp_fatal_ff      <= rsp_fatal_in;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot       = rsp_slot_ff;
   assign rsp_slot_valid = rsp_slot_valid_ff;
   assign rsp_issue_read = rsp_issue_ff;
   assign rsp_fatal      = rsp_fatal_ff;

   // Checks
   `SCSM_ASSERT_NOW(a_wr_only_decide, clock, reset, wr_en,
      state_ff == ST_DECIDE && out_free, "slot RAM written outside decide step")
   `SCSM_ASSERT_NOW(a_rsp_rise_decide, clock, reset, $rose(rsp_valid_ff),
      $past(state_ff) == ST_DECIDE, "result raised without a decide step")
   `SCSM_ASSERT_NOW(a_issue_has_slot, clock, reset, rsp_valid_ff && rsp_issue_ff,
      rsp_slot_valid_ff && !rsp_status_ff, "read issued without an allocated slot")
   `SCSM_ASSERT_NEXT(a_clock_quiet, clock, reset, state_ff != ST_DECIDE,
      $stable(use_clock_ff), "use clock moved outside decide step")
   `SCSM_ASSERT_NEXT(a_fatal_sticky, clock, reset, fatal_ff,
      fatal_ff, "fatal flag cleared without reset")

endmodule
